[src/bisd_pkg.sv]
// shared constants and types for the bitmap index set decoder
package bisd_pkg;

  localparam int DATA_W        = 64;
  localparam int IDX_W         = 32;
  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_WORD_BITS = 64;
  localparam int FIFO_DEPTH    = 2;

  typedef enum logic {
    CMD_HDR,
    CMD_WORD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [IDX_W-1:0]         base;
    logic [MAX_WORD_BITS-1:0] bits;
  } cmd_t;

endpackage

[src/bisd_ifs.sv]
// item channel interfaces for the bitmap index set decoder
interface bisd_in_if;
  logic        valid;
  logic        ready;
  logic        is_header;
  logic [63:0] data_word;

  modport source (output valid, output is_header, output data_word, input ready);
  modport sink (input valid, input is_header, input data_word, output ready);
endinterface

interface bisd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] index_value;
  logic        last_of_item;
  logic [31:0] decoded_count;

  modport source (output valid, output index_value, output last_of_item,
                  output decoded_count, input ready);
  modport sink (input valid, input index_value, input last_of_item,
                input decoded_count, output ready);
endinterface

[src/bisd_front.sv]
// front end: accepts items, tracks set position and queues decode commands
module bisd_front #(
  parameter int WORD_BITS = bisd_pkg::WORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  bisd_in_if.sink        in_ch,
  input  logic           fifo_full,
  output logic           push,
  output bisd_pkg::cmd_t cmd
);
  import bisd_pkg::*;

  logic [IDX_W-1:0] next_base_r, next_base_nxt;
  logic [IDX_W-1:0] words_left_r, words_left_nxt;
  logic             accept;

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && !fifo_full;

  always_comb begin
    push           = 1'b0;
    next_base_nxt  = next_base_r;
    words_left_nxt = words_left_r;
    cmd.kind       = CMD_WORD;
    cmd.base       = next_base_r;
    cmd.bits       = '0;
    cmd.bits[WORD_BITS-1:0] = in_ch.data_word[WORD_BITS-1:0];
    if (accept) begin
      if (in_ch.is_header) begin
        push           = 1'b1;
        cmd.kind       = CMD_HDR;
        cmd.base       = in_ch.data_word[2*IDX_W-1:IDX_W];
        words_left_nxt = in_ch.data_word[IDX_W-1:0];
        next_base_nxt  = in_ch.data_word[2*IDX_W-1:IDX_W] + IDX_W'(1);
      end else if (words_left_r != '0) begin
        push           = 1'b1;
        words_left_nxt = words_left_r - IDX_W'(1);
        next_base_nxt  = next_base_r + IDX_W'(WORD_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_base_r  <= '0;
      words_left_r <= '0;
    end else begin
      next_base_r  <= next_base_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

[src/bisd_fifo.sv]
// short command queue between front and back end
module bisd_fifo #(
  parameter int DEPTH = bisd_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bisd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bisd_pkg::cmd_t rd_data
);
  import bisd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

[src/bisd_back.sv]
// back end: walks set bits of a bitmap word and emits one index per cycle while the output is not stalled
module bisd_back #(
  parameter int WORD_BITS = bisd_pkg::WORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  bisd_pkg::cmd_t cmd,
  output logic           pop,
  bisd_out_if.source     out_ch
);
  import bisd_pkg::*;

  localparam int POS_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic                 busy_r;
  logic [WORD_BITS-1:0] word_r;
  logic [IDX_W-1:0]     base_r;
  logic [IDX_W-1:0]     count_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     index_r;
  logic                 last_r;

  logic                 adv;
  logic                 hdr_emit;
  logic                 bit_emit;
  logic [WORD_BITS-1:0] low_bit;
  logic [WORD_BITS-1:0] word_clr;
  logic [POS_W-1:0]     bit_pos;

  assign adv      = !out_valid_r || out_ch.ready;
  assign low_bit  = word_r & (~word_r + WORD_BITS'(1));
  assign word_clr = word_r & ~low_bit;

  always_comb begin
    bit_pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_bit[i]) begin
        bit_pos = bit_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    pop      = 1'b0;
    hdr_emit = 1'b0;
    bit_emit = 1'b0;
    if (busy_r) begin
      bit_emit = adv;
    end else if (cmd_valid) begin
      unique case (cmd.kind)
        CMD_HDR: begin
          pop      = adv;
          hdr_emit = adv;
        end
        CMD_WORD: begin
          pop = 1'b1;
        end
        default: begin
          pop = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (hdr_emit) begin
        out_valid_r <= 1'b1;
        index_r     <= cmd.base;
        last_r      <= 1'b1;
        count_r     <= IDX_W'(1);
      end
      if (bit_emit) begin
        out_valid_r <= 1'b1;
        index_r     <= base_r + IDX_W'(bit_pos);
        last_r      <= (word_clr == '0);
        count_r     <= count_r + IDX_W'(1);
        word_r      <= word_clr;
        busy_r      <= (word_clr != '0);
      end
      if (pop && (cmd.kind == CMD_WORD)) begin
        word_r <= cmd.bits[WORD_BITS-1:0];
        base_r <= cmd.base;
        busy_r <= (cmd.bits[WORD_BITS-1:0] != '0);
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.index_value   = index_r;
  assign out_ch.last_of_item  = last_r;
  assign out_ch.decoded_count = count_r;

  a_busy_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (word_r != '0))
    else $error("busy with an empty bitmap word");

  a_hdr_result: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_emit |=> (out_valid_r && last_r && (count_r == IDX_W'(1))))
    else $error("header item did not give a single counted result");

  a_busy_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(pop))
    else $error("walk started without a queued command");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop)
    else $error("command taken while a word is still being walked");

endmodule

[src/bitmap_index_set_decoder_top.sv]
// top level of the bitmap index set decoder
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    is_header, data_word[63:0]
//   out_ch   out  valid/ready    index_value[31:0], last_of_item, decoded_count[31:0]
//
// a header item gives one index; the back end walks a bitmap word's set bits
// one at a time with its single lowest-set-bit finder and takes no command meanwhile
// surplus bitmap words are accepted and dropped in the front end
// reset is synchronous and clears the set state, the command queue and the output
// the command queue lets the front accept until it fills while the output is stalled
module bitmap_index_set_decoder_top #(
  parameter int WORD_BITS  = bisd_pkg::WORD_BITS_DEF,
  parameter int FIFO_DEPTH = bisd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  bisd_in_if.sink     in_ch,
  bisd_out_if.source  out_ch
);
  import bisd_pkg::*;

  logic push;
  logic fifo_full;
  logic pop;
  logic cmd_valid;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  bisd_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  bisd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (cmd_valid),
    .rd_data   (rd_cmd)
  );

  bisd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (rd_cmd),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

[tb/sv/tb.sv]
// testbench for the bitmap index set decoder: directed table, then random sets checked by a predictor
`timescale 1ns / 100ps

module tb;
  import bisd_pkg::*;

  localparam int          WORD_BITS    = WORD_BITS_DEF;
  localparam logic [63:0] WORD_MASK    = (WORD_BITS == 64) ? '1 : ((64'd1 << WORD_BITS) - 64'd1);
  localparam int          DRAIN_CYCLES = 200;
  localparam int          LONG_HOLD    = 400;
  localparam int          RANDOM_ITEMS = 148;
  localparam int          SHOWN_ERRORS = 10;
  localparam int          N_DIRECTED   = 18;

  typedef struct packed {
    logic [31:0] index_value;
    logic        last_of_item;
    logic [31:0] decoded_count;
  } idx_result_t;

  typedef struct packed {
    logic        is_header;
    logic [63:0] data_word;
    logic        typed;
    logic [31:0] typed_index;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bisd_in_if  in_ch ();
  bisd_out_if out_ch ();

  bitmap_index_set_decoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // typed rows are headers: one index, last set, count one
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
    '{1'b1, 64'h0000_0010_0000_0003, 1'b1, 32'h0000_0010},
    '{1'b0, 64'h0000_0000_0000_0001, 1'b0, 32'h0},
    '{1'b0, 64'h0000_0000_0000_0000, 1'b0, 32'h0},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
    '{1'b0, 64'h0000_0000_0000_0001, 1'b0, 32'h0},
    '{1'b1, 64'hFFFF_FFF0_0000_0002, 1'b1, 32'hFFFF_FFF0},
    '{1'b0, 64'h8000_0000_0000_0001, 1'b0, 32'h0},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 64'h5555_5555_5555_5555, 1'b0, 32'h0},
    '{1'b1, 64'h0000_0000_0000_0001, 1'b1, 32'h0000_0000},
    '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0},
    '{1'b1, 64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
    '{1'b0, 64'h0000_0000_0000_00FF, 1'b0, 32'h0},
    '{1'b1, 64'h1234_5678_0000_0001, 1'b1, 32'h1234_5678},
    '{1'b0, 64'h8000_0000_0000_0000, 1'b0, 32'h0},
    '{1'b0, 64'h0000_0000_0000_0001, 1'b0, 32'h0}
  };

  logic [31:0] set_first;
  logic [31:0] set_words_left;
  logic [31:0] set_word_pos;
  logic [31:0] set_count;
  idx_result_t predicted [$];
  idx_result_t expected_indexes [$];
  int          fail_count;
  int          burst_left;
  bit          hold_off_req;

  function automatic bit decode_set_item(input logic hdr, input logic [63:0] word);
    logic [63:0] bits;
    logic [31:0] base;
    idx_result_t r;
    int          n;
    predicted.delete();
    if (hdr) begin
      set_words_left = word[31:0];
      set_first      = word[63:32];
      set_word_pos   = '0;
      set_count      = 32'd1;
      predicted.push_back(idx_result_t'{set_first, 1'b1, set_count});
      return 1'b1;
    end
    if (set_words_left == 0) return 1'b0;
    bits = word & WORD_MASK;
    base = set_first + set_word_pos * WORD_BITS + 32'd1;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (bits[b]) begin
        set_count = set_count + 32'd1;
        predicted.push_back(idx_result_t'{base + 32'(b), 1'b0, set_count});
      end
    end
    n = predicted.size();
    if (n > 0) begin
      r = predicted[n-1];
      r.last_of_item = 1'b1;
      predicted[n-1] = r;
    end
    set_words_left = set_words_left - 32'd1;
    set_word_pos   = set_word_pos + 32'd1;
    return 1'b1;
  endfunction

  function automatic logic [63:0] make_bitmap_word();
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = {$urandom, $urandom};
      3:       w = 64'd1 << $urandom_range(0, 63);
      default: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) $display("%0t: %s", $realtime, what);
  endtask

  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic offer_item(input logic hdr, input logic [63:0] word, input logic typed,
                            input logic [31:0] typed_index, output bit took);
    in_ch.valid     <= 1'b1;
    in_ch.is_header <= hdr;
    in_ch.data_word <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    took = decode_set_item(hdr, word);
    if (typed) expected_indexes.push_back(idx_result_t'{typed_index, 1'b1, 32'd1});
    else foreach (predicted[i]) expected_indexes.push_back(predicted[i]);
    pace_sender();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_indexes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("bitmap_index_set_decoder_top verification failed");
    $finish;
  end

  // receiver: stall pattern in segments, one long hold-off on request
  initial begin : receiver
    int seg_left;
    int mode;
    bit hold_done;
    seg_left  = 0;
    mode      = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(8, 60);
      end
      seg_left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    idx_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_indexes.size() == 0) begin
        note_failure($sformatf("unexpected item: index %h last %b count %0d",
                               out_ch.index_value, out_ch.last_of_item, out_ch.decoded_count));
      end else begin
        want = expected_indexes.pop_front();
        if (out_ch.index_value !== want.index_value ||
            out_ch.last_of_item !== want.last_of_item ||
            out_ch.decoded_count !== want.decoded_count)
          note_failure($sformatf("mismatch: expected index %h last %b count %0d, got %h %b %0d",
                                 want.index_value, want.last_of_item, want.decoded_count,
                                 out_ch.index_value, out_ch.last_of_item,
                                 out_ch.decoded_count));
      end
    end
  end

  initial begin : sender
    bit          took;
    int          consumed;
    int          set_num;
    int          kind;
    int          n_words;
    logic [31:0] first;
    logic [31:0] count;
    fail_count     = 0;
    burst_left     = $urandom_range(1, 16);
    hold_off_req   = 1'b0;
    consumed       = 0;
    set_num        = 0;
    set_first      = '0;
    set_words_left = '0;
    set_word_pos   = '0;
    set_count      = '0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.is_header <= 1'b0;
    in_ch.data_word <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].is_header, directed_rows[i].data_word,
                 directed_rows[i].typed, directed_rows[i].typed_index, took);
    drain_results();

    hold_off_req = 1'b1;
    while (consumed < RANDOM_ITEMS) begin
      set_num++;
      if (set_num == 12) drain_results();
      kind  = $urandom_range(0, 19);
      first = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255)) : $urandom;
      if (kind < 14) begin
        count   = $urandom_range(1, 5);
        n_words = count + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      end else if (kind < 16) begin
        count   = 32'd0;
        n_words = $urandom_range(0, 2);
      end else if (kind < 18) begin
        count   = $urandom | 32'h100;
        n_words = $urandom_range(1, 4);
      end else begin
        count   = $urandom_range(2, 5);
        n_words = $urandom_range(1, count - 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        offer_item(1'b0, {$urandom, $urandom}, 1'b0, '0, took);
        if (took) consumed++;
      end
      offer_item(1'b1, {first, count}, 1'b0, '0, took);
      consumed++;
      for (int w = 0; w < n_words; w++) begin
        offer_item(1'b0, make_bitmap_word(), 1'b0, '0, took);
        if (took) consumed++;
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("bitmap_index_set_decoder_top verification clean");
    end else begin
      $display("bitmap_index_set_decoder_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/bisd_pkg.sv
src/bisd_ifs.sv
src/bisd_front.sv
src/bisd_fifo.sv
src/bisd_back.sv
src/bitmap_index_set_decoder_top.sv
tb/sv/tb.sv
